// File: src/mxe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxe_pkg
// Shared types, constants and rounding helpers for the 3x3 matrix exponential.
// ----------------------------------------------------------------------------
package mxe_pkg;

  localparam int FracBits  = 16;
  localparam int MatrixDim = 3;
  localparam int Cells     = MatrixDim * MatrixDim;
  localparam int ElemW     = 32;
  localparam int ProdW     = 2 * ElemW;
  localparam int WideW     = 72;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [WideW-1:0] wide_t;
  typedef elem_t [Cells-1:0]       mat_t;

  typedef struct packed {
    mat_t p2;
    mat_t b;
  } side_t;

  typedef struct packed {
    elem_t a_r0c0;
    elem_t a_r0c1;
    elem_t a_r0c2;
    elem_t a_r1c0;
    elem_t a_r1c1;
    elem_t a_r1c2;
    elem_t a_r2c0;
    elem_t a_r2c1;
    elem_t a_r2c2;
    elem_t time_step;
  } in_item_t;

  typedef struct packed {
    elem_t e_r0c0;
    elem_t e_r0c1;
    elem_t e_r0c2;
    elem_t e_r1c0;
    elem_t e_r1c1;
    elem_t e_r1c2;
    elem_t e_r2c0;
    elem_t e_r2c1;
    elem_t e_r2c2;
  } out_item_t;

  localparam wide_t HalfLsb = wide_t'(1) <<< (FracBits - 1);
  localparam wide_t OneVal  = wide_t'(1) <<< FracBits;

  function automatic elem_t sat_elem(input wide_t x);
    elem_t r;
    if ((&x[WideW-1:ElemW-1]) || !(|x[WideW-1:ElemW-1])) begin
      r = x[ElemW-1:0];
    end else if (x[WideW-1]) begin
      r = {1'b1, {(ElemW-1){1'b0}}};
    end else begin
      r = {1'b0, {(ElemW-1){1'b1}}};
    end
    return r;
  endfunction

  // round to nearest, ties up, then saturate
  function automatic elem_t round_sat(input wide_t s);
    wide_t r;
    r = (s + HalfLsb) >>> FracBits;
    return sat_elem(r);
  endfunction

endpackage

// File: src/mxe_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxe_scale
// Two-stage scaling B = round(A * dt), saturated to 32 bits.
// ----------------------------------------------------------------------------
module mxe_scale (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mxe_pkg::mat_t     a,
  input  mxe_pkg::elem_t    dt,
  output logic              out_valid,
  input  logic              out_stall,
  output mxe_pkg::side_t    out_side
);

  logic v1, v2, ready1, ready2;
  mxe_pkg::prod_t [mxe_pkg::Cells-1:0] prod;
  mxe_pkg::mat_t b;

  assign ready2    = !v2 || !out_stall;
  assign ready1    = !v1 || ready2;
  assign in_stall  = !ready1;
  assign out_valid = v2;
  assign out_side  = '{p2: '0, b: b};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
    for (int c = 0; c < mxe_pkg::Cells; c++) begin
      if (ready1 && in_valid) prod[c] <= $signed(a[c]) * $signed(dt);
      if (ready2 && v1) b[c] <= mxe_pkg::round_sat(mxe_pkg::wide_t'(prod[c]));
    end
  end

endmodule

// File: src/mxe_matmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxe_matmul
// Two-stage 3x3 product: 27 multipliers, then rounded sums per element.
// ----------------------------------------------------------------------------
module mxe_matmul (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mxe_pkg::mat_t     x,
  input  mxe_pkg::mat_t     y,
  input  mxe_pkg::side_t    in_side,
  output logic              out_valid,
  input  logic              out_stall,
  output mxe_pkg::mat_t     z,
  output mxe_pkg::side_t    out_side
);

  localparam int N = mxe_pkg::MatrixDim;

  logic v1, v2, ready1, ready2;
  mxe_pkg::prod_t [mxe_pkg::Cells-1:0][N-1:0] prod;
  mxe_pkg::side_t side1;
  mxe_pkg::mat_t  sum_next;

  assign ready2    = !v2 || !out_stall;
  assign ready1    = !v1 || ready2;
  assign in_stall  = !ready1;
  assign out_valid = v2;

  always_comb begin
    for (int c = 0; c < mxe_pkg::Cells; c++) begin
      sum_next[c] = mxe_pkg::round_sat(mxe_pkg::wide_t'(prod[c][0])
                    + mxe_pkg::wide_t'(prod[c][1]) + mxe_pkg::wide_t'(prod[c][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
    if (ready1 && in_valid) begin
      side1 <= in_side;
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          for (int k = 0; k < N; k++) begin
            prod[i*N+j][k] <= $signed(x[i*N+k]) * $signed(y[k*N+j]);
          end
        end
      end
    end
    if (ready2 && v1) begin
      z        <= sum_next;
      out_side <= side1;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && out_stall))
    else $error("matmul stalls upstream without a full pipe");
  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (v2 && out_stall) |=> (v2 && $stable(z)))
    else $error("matmul result changed while held");
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!v1 && !v2))
    else $error("matmul pipe not empty after reset");
`endif

endmodule

// File: src/mxe_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxe_combine
// Two-stage final sum E = I + B + round((3*P2 + P3) / 6), saturated.
// ----------------------------------------------------------------------------
module mxe_combine (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mxe_pkg::mat_t     p3,
  input  mxe_pkg::side_t    in_side,
  output logic              out_valid,
  input  logic              out_stall,
  output mxe_pkg::mat_t     e
);

  localparam int N = mxe_pkg::MatrixDim;
  localparam int SplitBit = 18;
  localparam int RecipShift = 21;
  localparam logic [33:0] ChunkThird = 34'd87381;
  localparam logic [38:0] RecipThird = 39'd699051;
  localparam mxe_pkg::wide_t DivBias = mxe_pkg::wide_t'(1) <<< 33;
  localparam mxe_pkg::wide_t DivOffset = mxe_pkg::wide_t'(3) <<< 33;

  logic v1, v2, ready1, ready2;
  logic [mxe_pkg::Cells-1:0][33:0] ph, ph_next;
  logic [mxe_pkg::Cells-1:0][38:0] pv, pv_next;
  mxe_pkg::mat_t b1;
  mxe_pkg::mat_t e_next;

  assign ready2    = !v2 || !out_stall;
  assign ready1    = !v1 || ready2;
  assign in_stall  = !ready1;
  assign out_valid = v2;

  // floor((t+3)/6) as floor(u/3) with u offset to stay positive
  always_comb begin
    mxe_pkg::wide_t t, u;
    logic [16:0] uh;
    logic [17:0] ul;
    logic [18:0] v;
    for (int c = 0; c < mxe_pkg::Cells; c++) begin
      t = (mxe_pkg::wide_t'(in_side.p2[c]) <<< 1) + mxe_pkg::wide_t'(in_side.p2[c])
          + mxe_pkg::wide_t'(p3[c]);
      u = ((t + mxe_pkg::wide_t'(3)) >>> 1) + DivOffset;
      uh = u[34:SplitBit];
      ul = u[SplitBit-1:0];
      v  = {2'b0, uh} + {1'b0, ul};
      ph_next[c] = {17'b0, uh} * ChunkThird;
      pv_next[c] = {20'b0, v} * RecipThird;
    end
  end

  always_comb begin
    mxe_pkg::wide_t q, s;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        q = mxe_pkg::wide_t'({1'b0, ph[i*N+j]})
            + mxe_pkg::wide_t'({1'b0, pv[i*N+j][38:RecipShift]}) - DivBias;
        s = mxe_pkg::wide_t'(b1[i*N+j]) + q + ((i == j) ? mxe_pkg::OneVal : '0);
        e_next[i*N+j] = mxe_pkg::sat_elem(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
    if (ready1 && in_valid) begin
      ph <= ph_next;
      pv <= pv_next;
      b1 <= in_side.b;
    end
    if (ready2 && v1) e <= e_next;
  end

endmodule

// File: src/matrix_exponential_taylor_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_exponential_taylor_3x3_top
// Third-order Taylor approximation of exp(A*dt) for a 3x3 Q16.16 matrix.
// ----------------------------------------------------------------------------
// usage:
//   src channel carries one item: matrix A row by row plus time_step
//   dst channel returns one item: the nine elements of E row by row
//   an item is taken on an edge with valid high and stall low
//   dst_valid rises once the item has passed all eight register stages;
//   the result is taken on an edge with dst_stall low
//   one item per cycle sustained unless dst stalls; eight register stages
//   in four units (scale, two matrix products, final combine), each unit
//   two stages deep; each stage moves on as soon as its successor has room,
//   so bubbles fill while dst is stalled and nothing is dropped or repeated
//   a stalled dst item holds steady until taken
//   reset empties every stage; no other state is kept
// ----------------------------------------------------------------------------
module matrix_exponential_taylor_3x3_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  mxe_pkg::in_item_t   src_item,
  output logic                dst_valid,
  input  logic                dst_stall,
  output mxe_pkg::out_item_t  dst_item
);

  mxe_pkg::mat_t a, p2, p3, e;
  mxe_pkg::side_t sd_s, sd_1, sd_2, sd_3;
  logic v_s, st_s, v_1, st_1, v_2, st_2;

  assign a = {src_item.a_r2c2, src_item.a_r2c1, src_item.a_r2c0,
              src_item.a_r1c2, src_item.a_r1c1, src_item.a_r1c0,
              src_item.a_r0c2, src_item.a_r0c1, src_item.a_r0c0};

  assign dst_item = '{e_r0c0: e[0], e_r0c1: e[1], e_r0c2: e[2],
                      e_r1c0: e[3], e_r1c1: e[4], e_r1c2: e[5],
                      e_r2c0: e[6], e_r2c1: e[7], e_r2c2: e[8]};

  mxe_scale u_scale (
    .clk, .rst,
    .in_valid(src_valid), .in_stall(src_stall),
    .a(a), .dt(src_item.time_step),
    .out_valid(v_s), .out_stall(st_s), .out_side(sd_s)
  );

  mxe_matmul u_sq (
    .clk, .rst,
    .in_valid(v_s), .in_stall(st_s),
    .x(sd_s.b), .y(sd_s.b), .in_side(sd_s),
    .out_valid(v_1), .out_stall(st_1), .z(p2), .out_side(sd_1)
  );

  assign sd_2 = '{p2: p2, b: sd_1.b};

  mxe_matmul u_cube (
    .clk, .rst,
    .in_valid(v_1), .in_stall(st_1),
    .x(p2), .y(sd_1.b), .in_side(sd_2),
    .out_valid(v_2), .out_stall(st_2), .z(p3), .out_side(sd_3)
  );

  mxe_combine u_comb (
    .clk, .rst,
    .in_valid(v_2), .in_stall(st_2),
    .p3(p3), .in_side(sd_3),
    .out_valid(dst_valid), .out_stall(dst_stall), .e(e)
  );

endmodule
